// File: src/slpq_pkg.sv
// slpq_pkg: shared types and codes for the sorted table
// operation codes, widths and the command struct that the top level broadcasts to each cell
// no dependencies
`default_nettype none

package slpq_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned COUNT_OUT_W = 6;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2
	} op_t;

	// broadcast to every cell in the update cycle
	typedef struct packed {
		logic                      ins_en;
		logic                      del_en;
		logic signed [VALUE_W-1:0] value;
	} slpq_cmd_t;

endpackage

`default_nettype wire

// File: src/slpq_cell.sv
// slpq_cell: one slot of the sorted table
// holds one entry, compares it with the broadcast value and shifts to or from its neighbours
// depends on slpq_pkg
`default_nettype none

module slpq_cell (
	input  wire logic                               clk,
	input  wire slpq_pkg::slpq_cmd_t                cmd,
	input  wire logic                               occ,
	input  wire logic                               left_ge,
	input  wire logic signed [slpq_pkg::VALUE_W-1:0] left_value,
	input  wire logic signed [slpq_pkg::VALUE_W-1:0] right_value,
	output logic                                    ge,
	output logic                                    eq,
	output logic signed [slpq_pkg::VALUE_W-1:0]     value_q
);

	// an empty slot counts as not smaller, so the insert point is the first set ge
	assign ge = !occ || (cmd.value <= value_q);
	assign eq = occ && (cmd.value == value_q);

	always_ff @(posedge clk) begin
		if (cmd.ins_en && ge) begin
			value_q <= left_ge ? left_value : cmd.value;
		end else if (cmd.del_en && ge) begin
			value_q <= right_value;
		end
	end

endmodule

`default_nettype wire

// File: src/sorted_list_insert_delete_find.sv
// sorted_list_insert_delete_find: bounded sorted table with insert, delete and find
// an accepted item is captured with busy_q, updates the table while busy is high and then
// raises the done strobe from done_q; start is ignored during the single update cycle
// in which busy is high and the whole row of cells compares against the value and shifts in parallel
// reset: arst_n clears the count and control; entries hold no reset value
// the result is shown for one cycle only, the receiver cannot stall it
// depends on slpq_pkg and slpq_cell
`default_nettype none

module sorted_list_insert_delete_find #(
	parameter int unsigned CAPACITY = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [1:0]                             req_type,
	input  wire logic signed [slpq_pkg::VALUE_W-1:0]    value,
	output logic                                        done,
	output logic                                        hit,
	output logic                                        overflow,
	output logic [slpq_pkg::COUNT_OUT_W-1:0]            entry_count,
	output logic                                        is_empty,
	output logic                                        is_full
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// item held for the update cycle
	logic [1:0]                          op_s1;
	logic signed [slpq_pkg::VALUE_W-1:0] value_s1;

	logic          busy_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;

	logic          done_q;
	logic          hit_q;
	logic          overflow_q;
	logic          empty_q;
	logic          full_q;

	logic [CAPACITY-1:0] ge_vec;
	logic [CAPACITY-1:0] eq_vec;
	logic signed [slpq_pkg::VALUE_W-1:0] cell_val [CAPACITY];

	slpq_pkg::slpq_cmd_t cmd;

	logic accept;
	logic any_eq;
	logic full_now;
	logic hit_nxt;
	logic ovf_nxt;

	assign accept   = start && !busy_q;
	assign any_eq   = |eq_vec;
	assign full_now = (count_q == CW'(CAPACITY));

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= req_type;
			value_s1 <= value;
		end
	end

	// decode the operation for the update cycle
	always_comb begin
		cmd.ins_en = 1'b0;
		cmd.del_en = 1'b0;
		cmd.value  = value_s1;
		hit_nxt    = 1'b0;
		ovf_nxt    = 1'b0;
		count_nxt  = count_q;
		unique case (op_s1)
			slpq_pkg::OP_INSERT: begin
				if (full_now) begin
					ovf_nxt = 1'b1;
				end else begin
					cmd.ins_en = busy_q;
					hit_nxt    = 1'b1;
					count_nxt  = count_q + CW'(1);
				end
			end
			slpq_pkg::OP_DELETE: begin
				// sorted order: any match means the first not-smaller entry matches
				if (any_eq) begin
					cmd.del_en = busy_q;
					hit_nxt    = 1'b1;
					count_nxt  = count_q - CW'(1);
				end
			end
			slpq_pkg::OP_FIND: begin
				hit_nxt = any_eq;
			end
			default: begin
				// undefined code, table untouched
			end
		endcase
	end

	// row of cells, each talks to its neighbours only
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic                                occ;
			logic                                lge;
			logic signed [slpq_pkg::VALUE_W-1:0] lval;
			logic signed [slpq_pkg::VALUE_W-1:0] rval;

			assign occ = (count_q > CW'(gi));

			if (gi == 0) begin : g_first
				assign lge  = 1'b0;
				assign lval = value_s1;
			end else begin : g_mid
				assign lge  = ge_vec[gi-1];
				assign lval = cell_val[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign rval = value_s1;
			end else begin : g_inner
				assign rval = cell_val[gi+1];
			end

			slpq_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occ         (occ),
				.left_ge     (lge),
				.left_value  (lval),
				.right_value (rval),
				.ge          (ge_vec[gi]),
				.eq          (eq_vec[gi]),
				.value_q     (cell_val[gi])
			);
		end
	endgenerate

	// control, count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			count_q    <= '0;
			hit_q      <= 1'b0;
			overflow_q <= 1'b0;
			empty_q    <= 1'b1;
			full_q     <= 1'b0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				count_q    <= count_nxt;
				hit_q      <= hit_nxt;
				overflow_q <= ovf_nxt;
				empty_q    <= (count_nxt == '0);
				full_q     <= (count_nxt == CW'(CAPACITY));
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign hit      = hit_q;
	assign overflow = overflow_q;
	assign is_empty = empty_q;
	assign is_full  = full_q;

	// the count field carries only the low bits when the table is deep
	generate
		if (CW >= slpq_pkg::COUNT_OUT_W) begin : g_cnt_trunc
			assign entry_count = count_q[slpq_pkg::COUNT_OUT_W-1:0];
		end else begin : g_cnt_ext
			assign entry_count = {{(slpq_pkg::COUNT_OUT_W-CW){1'b0}}, count_q};
		end
	endgenerate

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> done_q && !busy_q)
		else $error("result strobe did not follow the update cycle");

	a_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && overflow_q |-> !hit_q && full_q)
		else $error("refused insert reported as hit or not full");

	a_miss_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !hit_q |-> count_q == $past(count_q))
		else $error("count changed on a miss");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (empty_q == (count_q == '0)) && (full_q == (count_q == CW'(CAPACITY))))
		else $error("empty or full flag out of step with count");

endmodule

`default_nettype wire

// File: dv/sorted_list_insert_delete_find_test.sv
// testbench for sorted_list_insert_delete_find: directed then random insert, delete and find items
// a scoreboard class predicts each result from a shadow copy of the table and checks the done strobe
// depends on slpq_pkg and the block under test
`timescale 1ns / 1ps

module sorted_list_insert_delete_find_test;

	localparam int unsigned CAPACITY     = 32;
	localparam int unsigned ITEM_TARGET  = 1700;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 10;

	// code with no operation behind it, the block must leave the table alone
	localparam logic [1:0] OP_UNDEFINED = 2'd3;

	localparam logic signed [slpq_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [slpq_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

	typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

	typedef struct packed {
		logic                             hit;
		logic                             overflow;
		logic [slpq_pkg::COUNT_OUT_W-1:0] entry_count;
		logic                             is_empty;
		logic                             is_full;
	} table_result_t;

	// shadow of the sorted table plus the queue of results still owed by the block
	class table_scoreboard;
		int unsigned                         capacity;
		logic signed [slpq_pkg::VALUE_W-1:0] rows[$];
		table_result_t                       owed[$];
		int unsigned                         errors;

		function new(int unsigned cap);
			capacity = cap;
			errors   = 0;
		endfunction

		// works out what the block must answer for one accepted item
		function void note_request(logic [1:0] op, logic signed [slpq_pkg::VALUE_W-1:0] val);
			table_result_t res;
			int            pos;
			res = '0;
			pos = -1;
			if (op == slpq_pkg::OP_INSERT) begin
				if (rows.size() >= capacity) begin
					res.overflow = 1'b1;
				end else begin
					// in front of the first entry that is not smaller
					pos = 0;
					while (pos < rows.size() && val > rows[pos])
						pos++;
					rows.insert(pos, val);
					res.hit = 1'b1;
				end
			end else if (op == slpq_pkg::OP_DELETE || op == slpq_pkg::OP_FIND) begin
				foreach (rows[i]) begin
					if (pos < 0 && rows[i] == val)
						pos = i;
				end
				if (pos >= 0) begin
					res.hit = 1'b1;
					if (op == slpq_pkg::OP_DELETE)
						rows.delete(pos);
				end
			end
			res.entry_count = slpq_pkg::COUNT_OUT_W'(rows.size());
			res.is_empty    = (rows.size() == 0);
			res.is_full     = (rows.size() == capacity);
			owed.push_back(res);
		endfunction

		function void compare_field(string name, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
				errors++;
			end
		endfunction

		function void check_result(table_result_t got);
			table_result_t exp;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing owed, expected none, actual %h", $time, got);
				errors++;
			end else begin
				exp = owed.pop_front();
				compare_field("hit", exp.hit, got.hit);
				compare_field("overflow", exp.overflow, got.overflow);
				compare_field("entry_count", exp.entry_count, got.entry_count);
				compare_field("is_empty", exp.is_empty, got.is_empty);
				compare_field("is_full", exp.is_full, got.is_full);
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic [1:0]                          req_type;
	logic signed [slpq_pkg::VALUE_W-1:0] value;
	logic                                done;
	logic                                hit;
	logic                                overflow;
	logic [slpq_pkg::COUNT_OUT_W-1:0]    entry_count;
	logic                                is_empty;
	logic                                is_full;

	table_scoreboard sb;
	int unsigned     cycle_count;
	int unsigned     items_sent;
	bit              burst_mode;

	sorted_list_insert_delete_find #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.done(done),
		.hit(hit),
		.overflow(overflow),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// results are sampled at the edge that ends their strobe cycle
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{hit, overflow, entry_count, is_empty, is_full});
	end

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_list_insert_delete_find_test: done, errors");
			$finish;
		end
	end

	// presents one item after an optional idle gap and returns at the edge that accepts it
	task automatic send_item(logic [1:0] op, logic signed [slpq_pkg::VALUE_W-1:0] val);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= op;
		value    <= val;
		// busy read at the edge is the value before the edge
		do @(posedge clk); while (busy);
		sb.note_request(op, val);
		items_sent++;
	endtask

	// operands: extremes, a narrow band around zero for duplicates, full range, or a stored entry
	function automatic logic signed [slpq_pkg::VALUE_W-1:0] pick_value();
		logic signed [slpq_pkg::VALUE_W-1:0] val;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: val = VALUE_MIN;
					1: val = VALUE_MAX;
					2: val = '0;
					default: val = -1;
				endcase
			end
			1, 2: val = int'($urandom_range(0, 12)) - 6;
			3, 4: val = $urandom;
			default: begin
				if (sb.rows.size() != 0)
					val = sb.rows[$urandom_range(0, sb.rows.size() - 1)];
				else
					val = int'($urandom_range(0, 12)) - 6;
			end
		endcase
		return val;
	endfunction

	// the fill and drain phases each lean on one operation so the table swings between empty and full
	function automatic logic [1:0] pick_op(phase_t phase);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (phase)
			PHASE_FILL: begin
				if (roll < 80) return slpq_pkg::OP_INSERT;
				else if (roll < 90) return slpq_pkg::OP_FIND;
				else if (roll < 95) return slpq_pkg::OP_DELETE;
				else return OP_UNDEFINED;
			end
			PHASE_DRAIN: begin
				if (roll < 70) return slpq_pkg::OP_DELETE;
				else if (roll < 85) return slpq_pkg::OP_FIND;
				else if (roll < 95) return slpq_pkg::OP_INSERT;
				else return OP_UNDEFINED;
			end
			default: begin
				if (roll < 35) return slpq_pkg::OP_INSERT;
				else if (roll < 65) return slpq_pkg::OP_DELETE;
				else if (roll < 95) return slpq_pkg::OP_FIND;
				else return OP_UNDEFINED;
			end
		endcase
	endfunction

	initial begin
		phase_t      phase;
		int unsigned phase_len;

		sb          = new(CAPACITY);
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = slpq_pkg::OP_INSERT;
		value       = '0;
		cycle_count = 0;
		items_sent  = 0;
		burst_mode  = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: operations on an empty table
		send_item(slpq_pkg::OP_FIND, '0);
		send_item(slpq_pkg::OP_DELETE, VALUE_MIN);
		send_item(OP_UNDEFINED, VALUE_MAX);
		// extremes and sign boundary, inserted out of order
		send_item(slpq_pkg::OP_INSERT, VALUE_MAX);
		send_item(slpq_pkg::OP_INSERT, VALUE_MIN);
		send_item(slpq_pkg::OP_INSERT, '0);
		send_item(slpq_pkg::OP_INSERT, -1);
		send_item(slpq_pkg::OP_INSERT, 1);
		// duplicates: delete takes only one copy
		send_item(slpq_pkg::OP_INSERT, 5);
		send_item(slpq_pkg::OP_INSERT, 5);
		send_item(slpq_pkg::OP_FIND, 5);
		send_item(slpq_pkg::OP_DELETE, 5);
		send_item(slpq_pkg::OP_FIND, 5);
		send_item(slpq_pkg::OP_DELETE, 5);
		send_item(slpq_pkg::OP_FIND, 5);
		// a populated table: a miss, hits on the extremes, an undefined code and deletes of the extremes
		send_item(slpq_pkg::OP_DELETE, 5);
		send_item(slpq_pkg::OP_FIND, 32'sh5555_aaaa);
		send_item(slpq_pkg::OP_FIND, VALUE_MIN);
		send_item(slpq_pkg::OP_FIND, VALUE_MAX);
		send_item(OP_UNDEFINED, -1);
		send_item(slpq_pkg::OP_DELETE, VALUE_MAX);
		send_item(slpq_pkg::OP_DELETE, VALUE_MIN);

		// random phases until the item budget is spent
		while (items_sent < ITEM_TARGET) begin
			phase      = phase_t'($urandom_range(0, 2));
			phase_len  = (phase == PHASE_MIXED) ? $urandom_range(20, 60)
			                                    : $urandom_range(45, 90);
			burst_mode = ($urandom_range(0, 3) == 0);
			repeat (phase_len) send_item(pick_op(phase), pick_value());
		end
		burst_mode = 1'b0;
		start <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("sorted_list_insert_delete_find_test: done, clean");
		end else begin
			$display("sorted_list_insert_delete_find_test: done, errors");
		end
		$finish;
	end

endmodule
